FILE: hw/rtl/rdt_pkg.sv
package rdt_pkg;

	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned DELAY_W  = 32;

	// Command codes; the remaining code of the field is ignored.
	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK             = 3'd0,
		OP_SET              = 3'd1,
		OP_SYNC_SET         = 3'd2,
		OP_CHANGE           = 3'd3,
		OP_CHECK            = 3'd4,
		OP_CHECK_RESTART    = 3'd5,
		OP_CHECK_RESTART_SY = 3'd6
	} opcode_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [DELAY_W-1:0]  delay_ms;
	} cmd_t;

	typedef struct packed {
		logic answer_flag;
		logic armed_flag;
	} res_t;

endpackage

FILE: hw/rtl/rdt_if.sv
interface rdt_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [rdt_pkg::OPCODE_W-1:0]    opcode;
	logic [rdt_pkg::DELAY_W-1:0]     delay_ms;

	modport source (output valid, output opcode, output delay_ms, input ready);
	modport sink   (input valid, input opcode, input delay_ms, output ready);
endinterface

interface rdt_res_if;
	logic valid;
	logic ready;
	logic answer_flag;
	logic armed_flag;

	modport source (output valid, output answer_flag, output armed_flag, input ready);
	modport sink   (input valid, input answer_flag, input armed_flag, output ready);
endinterface

FILE: hw/rtl/restartable_delay_timer_unit.sv
// Channel | Dir | Handshake     | Payload
// --------+-----+---------------+------------------------------------------
// cmd     | in  | valid / ready | opcode[2:0], delay_ms[31:0]
// res     | out | valid / ready | answer_flag, armed_flag
//
// One result word per command word; one word per cycle sustained while res.ready stays high.
// A command passes an input register, then the timer update and a result register.
// The timer state updates in the cycle a command moves into the result register.
// arst_n clears the time counter, the window, the armed flag and both valid bits.
// A stalled result holds its register; the input register still takes one more word if it is empty.
module restartable_delay_timer_unit #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	rdt_cmd_if.sink  cmd,
	rdt_res_if.source res
);

	logic          valid_s1;
	rdt_pkg::cmd_t cmd_s1;
	logic          advance;
	rdt_pkg::res_t res_d;
	rdt_pkg::res_t res_q;
	logic          res_valid_q;

	// Move the held command on when the result register is free or being emptied.
	assign advance = valid_s1 && (!res_valid_q || res.ready);

	rdt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1)
	);

	rdt_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd_s1  (cmd_s1),
		.res_d   (res_d)
	);

	// Result register: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.answer_flag = res_q.answer_flag;
	assign res.armed_flag  = res_q.armed_flag;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !res_valid_q || res.ready)
		else $error("result word overwritten before it was taken");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("advanced command produced no result word");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_valid_q |-> advance)
		else $error("held command stalled with an empty result register");

endmodule

FILE: hw/rtl/rdt_in_stage.sv
module rdt_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	rdt_cmd_if.sink       cmd,
	input  logic          advance,
	output logic          valid_s1,
	output rdt_pkg::cmd_t cmd_s1
);

	logic take;

	// Accept whenever the stage is empty or drains this cycle.
	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.opcode   <= cmd.opcode;
			cmd_s1.delay_ms <= cmd.delay_ms;
		end
	end

endmodule

FILE: hw/rtl/rdt_core.sv
module rdt_core #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  rdt_pkg::cmd_t cmd_s1,
	output rdt_pkg::res_t res_d
);

	logic [TIME_WIDTH-1:0] time_q, start_q, delay_q;
	logic                  armed_q;
	logic [TIME_WIDTH-1:0] time_d, start_d, delay_d;
	logic                  armed_d;
	logic [TIME_WIDTH-1:0] len, elapsed, deadline;
	logic                  expired, answer;
	rdt_pkg::opcode_t      op;

	assign op       = rdt_pkg::opcode_t'(cmd_s1.opcode);
	assign len      = TIME_WIDTH'(cmd_s1.delay_ms);
	assign elapsed  = time_q - start_q;
	assign deadline = start_q + delay_q;
	// A disarmed timer reads as expired.
	assign expired  = !armed_q || (elapsed >= delay_q);

	always_comb begin
		time_d  = time_q;
		start_d = start_q;
		delay_d = delay_q;
		armed_d = armed_q;
		answer  = 1'b0;
		unique case (op)
			rdt_pkg::OP_TICK: begin
				time_d = time_q + TIME_WIDTH'(1);
			end
			rdt_pkg::OP_SET: begin
				if (len == '0) begin
					armed_d = 1'b0;
				end else begin
					start_d = time_q;
					delay_d = len;
					armed_d = 1'b1;
				end
			end
			rdt_pkg::OP_SYNC_SET: begin
				if (len == '0) begin
					armed_d = 1'b0;
				end else begin
					start_d = armed_q ? time_q : deadline;
					delay_d = len;
					armed_d = 1'b1;
				end
			end
			rdt_pkg::OP_CHANGE: begin
				if (len == '0) begin
					armed_d = 1'b0;
				end else if (armed_q) begin
					delay_d = len;
					answer  = 1'b1;
				end
			end
			rdt_pkg::OP_CHECK: begin
				answer = expired;
				if (expired) begin
					armed_d = 1'b0;
				end
			end
			rdt_pkg::OP_CHECK_RESTART: begin
				answer = expired;
				if (expired) begin
					armed_d = (delay_q != '0);
					if (delay_q != '0) begin
						start_d = time_q;
					end
				end
			end
			rdt_pkg::OP_CHECK_RESTART_SY: begin
				// On expiry, re-arm from the old deadline if the length is nonzero, else disarm.
				answer = expired;
				if (expired) begin
					armed_d = (delay_q != '0);
					if (delay_q != '0) begin
						start_d = deadline;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res_d.answer_flag = answer;
	assign res_d.armed_flag  = armed_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			start_q <= '0;
			delay_q <= '0;
			armed_q <= 1'b0;
		end else if (advance) begin
			time_q  <= time_d;
			start_q <= start_d;
			delay_q <= delay_d;
			armed_q <= armed_d;
		end
	end

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op == rdt_pkg::OP_TICK |=> time_q == $past(time_q) + TIME_WIDTH'(1))
		else $error("time counter did not advance on tick");

	a_time_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && op == rdt_pkg::OP_TICK) |=> $stable(time_q))
		else $error("time counter moved without a tick");

	a_arm_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(armed_q) |-> $past(advance))
		else $error("timer armed without a command");

	a_armed_len: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> delay_q != '0)
		else $error("timer armed with zero length");

	a_change_armed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op == rdt_pkg::OP_CHANGE && answer |-> armed_q && res_d.armed_flag)
		else $error("change accepted on a disarmed timer");

endmodule
